[design/lscr_pkg.sv]
// Shared constants, types and control/status bundles for the light command responder.
`default_nettype none

package lscr_pkg;

    // Storage limits
    localparam int TABLE_SLOTS     = 8;
    localparam int MAX_LIGHTS_DFLT = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_W           = 4;

    // Command bytes
    localparam logic [7:0] OP_STATUS = 8'h01;
    localparam logic [7:0] OP_CHAR   = 8'h0f;
    localparam logic [7:0] OP_INDIV  = 8'h41;
    localparam logic [7:0] OP_GROUP  = 8'h42;

    // Reply command bytes
    localparam logic [7:0] RESP_STATUS = 8'h81;
    localparam logic [7:0] RESP_CHAR   = 8'h8f;
    localparam logic [7:0] RESP_INDIV  = 8'hc1;

    // Reply lengths
    localparam logic [LEN_W-1:0] LEN_CHAR_OLD = 4'd5;
    localparam logic [LEN_W-1:0] LEN_CHAR_NEW = 4'd11;
    localparam logic [LEN_W-1:0] LEN_INDIV    = 4'd2;

    localparam logic [3:0] ALL_LIGHTS_NIBBLE = 4'hf;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USE_OLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FMT_VER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_CNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_TABLE  = 3'd4;

    // Register reset values
    localparam logic             RST_USE_OLD   = 1'b1;
    localparam logic [7:0]       RST_FMT_VER   = 8'hff;
    localparam logic [7:0]       RST_VENDOR    = 8'hff;
    localparam logic [3:0]       RST_LIGHT_CNT = 4'd1;
    localparam logic [63:0]      RST_ID_TABLE  = 64'h11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEND
    } lscr_state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic emit;
    } lscr_cmd_t;

    typedef struct packed {
        logic reply_any;
        logic can_emit;
        logic at_last;
    } lscr_status_t;

endpackage

`default_nettype wire

[design/lscr_ctrl.sv]
// Sequencer: load, decode, then send reply beats.
`default_nettype none

module lscr_ctrl
    import lscr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire lscr_status_t st,
    output lscr_cmd_t         cmd
);

    lscr_state_t state_reg;
    lscr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = st.reply_any ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (st.can_emit && st.at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.decode = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            ST_SEND:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // accepted beat always goes to decode next
    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accept not followed by decode");

    // send is only entered when decode found a reply
    a_send_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECODE && !st.reply_any) |=> (state_reg == ST_IDLE))
        else $error("send entered with no reply");

    // no new beat is taken while a reply is in flight
    a_no_accept_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && !(st.can_emit && st.at_last)) |=> !in_ready)
        else $error("accept during reply");

endmodule

`default_nettype wire

[design/lscr_dp.sv]
// Datapath: config registers, power bits, light matching and reply byte generation.
`default_nettype none

module lscr_dp
    import lscr_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DFLT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lscr_cmd_t             cmd,
    output lscr_status_t               st,
    input  wire logic [7:0]            op,
    input  wire logic [7:0]            sub_id,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 resp_type,
    output logic [7:0]                 body_byte,
    output logic                       last
);

    localparam int SLOTS = (MAX_LIGHTS < TABLE_SLOTS) ? MAX_LIGHTS : TABLE_SLOTS;

    // config
    logic        use_old_reg;
    logic [7:0]  fmt_ver_reg;
    logic [7:0]  vendor_reg;
    logic [3:0]  light_cnt_reg;
    logic [63:0] id_table_reg;

    // item and reply state
    logic [7:0]       op_reg;
    logic [7:0]       sid_reg;
    logic             on_reg;
    logic [SLOTS-1:0] power_reg;
    logic [SLOTS-1:0] power_next;
    logic [SLOTS-1:0] pend_reg;
    logic [SLOTS-1:0] pend_next;
    logic [7:0]       rtype_reg;
    logic [7:0]       rtype_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] idx_reg;
    logic             indiv_reg;

    logic             out_valid_reg;
    logic [7:0]       out_type_reg;
    logic [7:0]       out_body_reg;
    logic             out_last_reg;

    logic [3:0]       n_use;
    logic [SLOTS-1:0] match_vec;
    logic [SLOTS-1:0] exact_vec;
    logic [SLOTS-1:0] low_bit;
    logic [LEN_W-1:0] hit_cnt;
    logic             is_ctl;
    logic             fire;
    logic [7:0]       byte_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_old_reg   <= RST_USE_OLD;
            fmt_ver_reg   <= RST_FMT_VER;
            vendor_reg    <= RST_VENDOR;
            light_cnt_reg <= RST_LIGHT_CNT;
            id_table_reg  <= RST_ID_TABLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_USE_OLD:   use_old_reg   <= cfg_data[0];
                CFG_FMT_VER:   fmt_ver_reg   <= cfg_data[7:0];
                CFG_VENDOR:    vendor_reg    <= cfg_data[7:0];
                CFG_LIGHT_CNT: light_cnt_reg <= cfg_data[3:0];
                CFG_ID_TABLE:  id_table_reg  <= cfg_data;
                default:       use_old_reg   <= use_old_reg;
            endcase
        end
    end

    // lights in use: min(light_count, SLOTS)
    assign n_use = (light_cnt_reg > 4'(SLOTS)) ? 4'(SLOTS) : light_cnt_reg;

    always_comb
    begin
        hit_cnt = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            exact_vec[i] = (4'(i) < n_use) && (sid_reg == id_table_reg[8*i +: 8]);
            match_vec[i] = (4'(i) < n_use)
                && ((sid_reg[3:0] == ALL_LIGHTS_NIBBLE) || (sid_reg == id_table_reg[8*i +: 8]));
            hit_cnt = hit_cnt + LEN_W'(match_vec[i]);
        end
    end

    assign is_ctl  = (op_reg == OP_INDIV) || (op_reg == OP_GROUP);
    assign low_bit = pend_reg & (~pend_reg + 1'b1);

    // decode: reply type and length
    always_comb
    begin
        rtype_next = '0;
        len_next   = '0;
        priority if (op_reg == OP_STATUS)
        begin
            rtype_next = RESP_STATUS;
            len_next   = hit_cnt + 1'b1;
        end
        else if (op_reg == OP_CHAR)
        begin
            rtype_next = RESP_CHAR;
            len_next   = use_old_reg ? LEN_CHAR_OLD : LEN_CHAR_NEW;
        end
        else if (op_reg == OP_INDIV)
        begin
            rtype_next = RESP_INDIV;
            len_next   = LEN_INDIV;
        end
        else
        begin
            rtype_next = '0;
        end
    end

    assign st.reply_any = ((op_reg == OP_STATUS) && (|match_vec))
        || (op_reg == OP_CHAR) || (op_reg == OP_INDIV);
    assign st.can_emit  = !out_valid_reg || out_ready;
    assign st.at_last   = (idx_reg == len_reg - 1'b1);
    assign fire         = cmd.emit && st.can_emit;

    // body byte for the current index
    always_comb
    begin
        byte_cur = '0;
        unique case (rtype_reg)
            RESP_STATUS:
            begin
                if (idx_reg != '0)
                begin
                    byte_cur = {7'd0, |(low_bit & power_reg)};
                end
            end
            RESP_CHAR:
            begin
                if (use_old_reg)
                begin
                    if (idx_reg == 4'd1)
                    begin
                        byte_cur = {4'd0, light_cnt_reg};
                    end
                end
                else
                begin
                    unique case (idx_reg)
                        4'd0:    byte_cur = fmt_ver_reg;
                        4'd1:    byte_cur = vendor_reg;
                        4'd2:    byte_cur = {4'd0, light_cnt_reg};
                        default: byte_cur = '0;
                    endcase
                end
            end
            RESP_INDIV:
            begin
                if (idx_reg == 4'd1)
                begin
                    byte_cur = {7'd0, indiv_reg};
                end
            end
            default:
            begin
                byte_cur = '0;
            end
        endcase
    end

    always_comb
    begin
        power_next = power_reg;
        if (cmd.decode && is_ctl)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (match_vec[i])
                begin
                    power_next[i] = on_reg;
                end
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd.decode)
        begin
            pend_next = match_vec;
        end
        else if (fire && (rtype_reg == RESP_STATUS) && (idx_reg != '0))
        begin
            pend_next = pend_reg & ~low_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            power_reg <= power_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.decode)
            begin
                idx_reg <= '0;
            end
            else if (fire)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            sid_reg <= sub_id;
            on_reg  <= (data_byte != 8'd0);
        end
        if (cmd.decode)
        begin
            rtype_reg <= rtype_next;
            len_reg   <= len_next;
            // exact-id lights are a subset of matches, so they now hold on_reg
            indiv_reg <= on_reg && (|exact_vec);
        end
        pend_reg <= pend_next;
        if (fire)
        begin
            out_type_reg <= rtype_reg;
            out_body_reg <= byte_cur;
            out_last_reg <= st.at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign resp_type = out_type_reg;
    assign body_byte = out_body_reg;
    assign last      = out_last_reg;

    // power bits only move on a control decode
    a_power_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.decode && is_ctl) |=> $stable(power_reg))
        else $error("power bits changed outside control");

    // never send past the reply length
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (idx_reg < len_reg))
        else $error("reply index overrun");

    // status reply length tracks the pending light mask
    a_status_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decode && (op_reg == OP_STATUS)) |=> (32'(len_reg) == $countones(pend_reg) + 1))
        else $error("status length mismatch");

endmodule

`default_nettype wire

[design/light_serial_command_responder_core.sv]
// Top level of the light command responder: sequencer plus datapath.
`default_nettype none

// Flow: a command beat is taken in idle and registered, then decoded in the decode state
// (reply type and length registered), then each reply beat is registered in send.
// A reply has 0 to 11 beats; the next command is taken once its last beat is sent.
// The single reply byte generator sends one beat per cycle while the output is not stalled.
// Reset (rst_n low, async): power bits all off, config to defaults, no reply pending.

module light_serial_command_responder_core
    import lscr_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DFLT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            op,
    input  wire logic [7:0]            sub_id,
    input  wire logic [7:0]            data_byte,
    // reply channel, one beat per body byte
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 resp_type,
    output logic [7:0]                 body_byte,
    output logic                       last,
    // register write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    lscr_cmd_t    cmd;
    lscr_status_t st;

    // Controller: idle -> decode -> send; in_ready only while idle.
    lscr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath holds the command, power bits and the output register; the
    // output register lets the next command be taken while the last beat waits.
    lscr_dp #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .op        (op),
        .sub_id    (sub_id),
        .data_byte (data_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .resp_type (resp_type),
        .body_byte (body_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

[tb/tb_light_serial_command_responder_core.sv]
// Self-checking testbench for the light command responder core.
`timescale 1ns / 1ps

module tb_light_serial_command_responder_core;
    import lscr_pkg::*;

    // Lights the block can address, as the core is built with its default size
    localparam int LIGHTS_MAX    = MAX_LIGHTS_DFLT;
    // Extra cycles after the last reply beat before registers change or the run ends
    localparam int SETTLE_CYCLES = 16;
    // Bound on the wait for outstanding reply beats
    localparam int DRAIN_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    // One reply beat as the core should present it
    typedef struct packed {
        logic [7:0] resp_type;
        logic [7:0] body;
        logic       last;
    } reply_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            op;
    logic [7:0]            sub_id;
    logic [7:0]            data_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            resp_type;
    logic [7:0]            body_byte;
    logic                  last;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the core's registers and power bits
    logic                  old_layout;
    logic [7:0]            fmt_version;
    logic [7:0]            vendor;
    logic [3:0]            count_reg;
    logic [63:0]           id_table;
    logic [7:0]            lamp_on;

    // Reply beats predicted but not yet seen, oldest first
    reply_beat_t           expected_beats[$];
    int                    fail_count;
    // Set for the last part of the run: no gaps, no stalls
    bit                    calm_mode;

    light_serial_command_responder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .sub_id    (sub_id),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .resp_type (resp_type),
        .body_byte (body_byte),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tb_light_serial_command_responder_core: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Light model
    // ------------------------------------------------------------------

    // Lights in use: the written count, capped by the build and the table
    function automatic int active_lights();
        int n;
        n = count_reg;
        if (n > LIGHTS_MAX) n = LIGHTS_MAX;
        if (n > TABLE_SLOTS) n = TABLE_SLOTS;
        return n;
    endfunction

    function automatic logic [7:0] light_id(input int idx);
        return id_table[8*idx +: 8];
    endfunction

    // Broadcast nibble hits everything; otherwise exact id compare
    function automatic bit light_hit(input int idx, input logic [7:0] sid);
        return (sid[3:0] == ALL_LIGHTS_NIBBLE) || (sid == light_id(idx));
    endfunction

    function automatic void set_power(input logic [7:0] sid, input logic turn_on);
        for (int i = 0; i < active_lights(); i++)
            if (light_hit(i, sid)) lamp_on[i] = turn_on;
    endfunction

    // Updates the shadow state for one accepted command and queues its reply beats
    function automatic void predict_command(input logic [7:0] cmd_op, input logic [7:0] cmd_sid,
                                            input logic [7:0] cmd_data);
        logic [7:0]  body [0:10];
        int          len;
        int          hits;
        int          n;
        logic [7:0]  rtype;
        reply_beat_t beat;
        n = active_lights();
        len = 0;
        hits = 0;
        rtype = 8'h00;
        for (int k = 0; k < 11; k++) body[k] = 8'h00;
        case (cmd_op)
            OP_STATUS:
            begin
                rtype = RESP_STATUS;
                for (int i = 0; i < n; i++)
                begin
                    if (light_hit(i, cmd_sid))
                    begin
                        body[1 + hits] = {7'b0, lamp_on[i]};
                        hits++;
                    end
                end
                len = (hits != 0) ? hits + 1 : 0;
            end
            OP_CHAR:
            begin
                rtype = RESP_CHAR;
                if (old_layout)
                begin
                    body[1] = {4'b0, count_reg};
                    len = LEN_CHAR_OLD;
                end
                else
                begin
                    body[0] = fmt_version;
                    body[1] = vendor;
                    body[2] = {4'b0, count_reg};
                    len = LEN_CHAR_NEW;
                end
            end
            OP_INDIV:
            begin
                set_power(cmd_sid, cmd_data != 8'h00);
                rtype = RESP_INDIV;
                // only exact id matches count here, not the broadcast nibble
                for (int i = 0; i < n; i++)
                    if (cmd_sid == light_id(i) && lamp_on[i]) body[1] = 8'h01;
                len = LEN_INDIV;
            end
            OP_GROUP:
                set_power(cmd_sid, cmd_data != 8'h00);
            default: ;
        endcase
        for (int k = 0; k < len; k++)
        begin
            beat.resp_type = rtype;
            beat.body      = body[k];
            beat.last      = (k + 1 == len);
            expected_beats = {expected_beats, beat};
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Every accepted reply beat is matched against the oldest prediction
    always @(posedge clk)
    begin : reply_monitor
        reply_beat_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_beats.size() == 0)
                note_failure($sformatf("unexpected reply beat: type=%02h body=%02h last=%0b",
                                       resp_type, body_byte, last));
            else
            begin
                want = expected_beats.pop_front();
                if (resp_type !== want.resp_type || body_byte !== want.body
                    || last !== want.last)
                    note_failure($sformatf(
                        "reply beat: expected type=%02h body=%02h last=%0b, got %02h %02h %0b",
                        want.resp_type, want.body, want.last, resp_type, body_byte, last));
            end
        end
    end

    // Reply side back-pressure: random stall bursts
    initial
    begin : reply_ready_driver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm_mode && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void reset_model();
        old_layout  = RST_USE_OLD;
        fmt_version = RST_FMT_VER;
        vendor      = RST_VENDOR;
        count_reg   = RST_LIGHT_CNT;
        id_table    = RST_ID_TABLE;
        lamp_on     = '0;
    endfunction

    // One register write; only called while the core is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_USE_OLD:   old_layout  = value[0];
            CFG_FMT_VER:   fmt_version = value[7:0];
            CFG_VENDOR:    vendor      = value[7:0];
            CFG_LIGHT_CNT: count_reg   = value[3:0];
            CFG_ID_TABLE:  id_table    = value;
            default: ;  // spare index, core ignores it
        endcase
    endtask

    // Random upper bits check that only the register's own width is kept
    function automatic logic [63:0] noisy(input logic [63:0] value, input int width);
        logic [63:0] mask;
        mask = (64'd1 << width) - 64'd1;
        return ({$urandom, $urandom} & ~mask) | (value & mask);
    endfunction

    // Sends one command beat, with an optional gap first, and predicts it on acceptance
    task automatic send_command(input logic [7:0] cmd_op, input logic [7:0] cmd_sid,
                                input logic [7:0] cmd_data);
        int gap;
        @(negedge clk);
        if (!calm_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= cmd_op;
        sub_id    <= cmd_sid;
        data_byte <= cmd_data;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_command(cmd_op, cmd_sid, cmd_data);
    endtask

    // Lowers valid, waits out all predicted beats, then lets a silent command finish
    task automatic drain_replies();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (expected_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults after reset: one light, id 0x11, old layout
    task automatic test_reset_defaults();
        send_command(OP_STATUS, 8'hff, 8'h00);
        send_command(OP_CHAR,   8'h00, 8'hff);
        send_command(OP_INDIV,  8'h11, 8'h01);
        send_command(OP_STATUS, 8'h11, 8'h00);
        send_command(OP_STATUS, 8'h22, 8'h00);  // no light matches: silent
        drain_replies();
    endtask

    // Eight lights with shared ids, an id with the broadcast nibble and id 0x00
    task automatic test_power_control();
        write_reg(CFG_LIGHT_CNT, 64'd8);
        write_reg(CFG_ID_TABLE,  64'h005a5a332fc4ff11);
        send_command(OP_INDIV,  8'h5a, 8'hff);  // two lights on at once
        send_command(OP_STATUS, 8'h5a, 8'h00);
        send_command(OP_GROUP,  8'h0f, 8'h00);  // broadcast off, no reply
        send_command(OP_STATUS, 8'hff, 8'h00);
        send_command(OP_GROUP,  8'h33, 8'h01);
        send_command(OP_INDIV,  8'h2f, 8'h80);  // broadcast on; exact id 0x2f counts
        send_command(OP_INDIV,  8'h77, 8'h01);  // no match, reply still sent
        send_command(OP_INDIV,  8'h00, 8'h00);
        send_command(OP_STATUS, 8'hff, 8'h00);
        drain_replies();
    endtask

    // Bit 7 set or unknown type: no reply, no state change
    task automatic test_ignored_commands();
        logic [7:0] junk_ops [0:4];
        junk_ops = '{8'h81, 8'hc1, 8'hff, 8'h00, 8'h43};
        foreach (junk_ops[k]) send_command(junk_ops[k], 8'hff, 8'hff);
        send_command(OP_STATUS, 8'hff, 8'h00);
        drain_replies();
    endtask

    // New layout at both byte extremes; light count zero and beyond the table
    task automatic test_char_layouts();
        write_reg(CFG_USE_OLD,   noisy(64'd0, 1));
        write_reg(CFG_FMT_VER,   noisy(64'h00, 8));
        write_reg(CFG_VENDOR,    noisy(64'h00, 8));
        write_reg(CFG_LIGHT_CNT, noisy(64'd0, 4));
        send_command(OP_CHAR,   8'h3c, 8'h00);
        send_command(OP_STATUS, 8'hff, 8'h00);  // no lights in use: silent
        send_command(OP_INDIV,  8'hff, 8'h01);
        drain_replies();
        write_reg(CFG_FMT_VER,   64'hff);
        write_reg(CFG_VENDOR,    64'hff);
        write_reg(CFG_LIGHT_CNT, 64'd15);       // capped to eight, reported as 15
        send_command(OP_CHAR,   8'h00, 8'h00);
        send_command(OP_STATUS, 8'hff, 8'h00);
        drain_replies();
        write_reg(CFG_USE_OLD,   64'd1);
        send_command(OP_CHAR,   8'hff, 8'hff);
        drain_replies();
    endtask

    // Writes to indexes past the last register must not land anywhere
    task automatic test_spare_registers();
        for (int idx = int'(CFG_ID_TABLE) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(idx[CFG_IDX_W-1:0], {$urandom, $urandom});
        send_command(OP_CHAR,   8'h00, 8'h00);
        send_command(OP_STATUS, 8'hff, 8'h00);
        drain_replies();
    endtask

    // One random phase: fresh registers, then mostly well-formed commands
    task automatic run_random_phase(input int phase, input int items);
        logic [7:0]  r_op;
        logic [7:0]  r_sid;
        logic [7:0]  r_data;
        logic [63:0] id_bytes;
        logic [7:0]  id_pool [0:2];
        logic [3:0]  cnt;
        int          pick;
        int          slot;
        id_pool = '{8'h11, 8'h2f, 8'h5a};
        // duplicate ids are common so exact-match and multi-hit paths get exercised
        for (int k = 0; k < 8; k++)
            id_bytes[8*k +: 8] = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 2)]
                                                             : 8'($urandom);
        case (phase)
            0:       cnt = 4'd8;
            1:       cnt = 4'd15;
            3:       cnt = 4'd1;
            4:       cnt = 4'($urandom_range(2, 7));
            5:       cnt = 4'd8;
            default: cnt = 4'($urandom_range(0, 15));
        endcase
        write_reg(CFG_USE_OLD,   noisy(64'($urandom_range(0, 1)), 1));
        write_reg(CFG_FMT_VER,   noisy((phase == 0) ? 64'h00 : (phase == 1) ? 64'hff
                                                             : 64'($urandom), 8));
        write_reg(CFG_VENDOR,    noisy((phase == 0) ? 64'hff : (phase == 1) ? 64'h00
                                                             : 64'($urandom), 8));
        write_reg(CFG_LIGHT_CNT, noisy(64'(cnt), 4));
        write_reg(CFG_ID_TABLE,  id_bytes);
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      r_op = OP_STATUS;
            else if (pick < 42) r_op = OP_CHAR;
            else if (pick < 65) r_op = OP_INDIV;
            else if (pick < 85) r_op = OP_GROUP;
            else                r_op = 8'($urandom);  // noise: mostly ignored types
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                slot = $urandom_range(0, 7);  // may be a slot past the count
                r_sid = id_table[8*slot +: 8];
            end
            else if (pick < 6)
                r_sid = {4'($urandom), ALL_LIGHTS_NIBBLE};
            else
                r_sid = 8'($urandom);
            r_data = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            send_command(r_op, r_sid, r_data);
        end
        drain_replies();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
            run_random_phase(phase, 40);
        // closing stretch runs back to back with no gaps and no stalls
        calm_mode = 1'b1;
        run_random_phase(5, 35);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        fail_count = 0;
        calm_mode  = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = 8'h00;
        sub_id     = 8'h00;
        data_byte  = 8'h00;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        reset_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_power_control();
        test_ignored_commands();
        test_char_layouts();
        test_spare_registers();
        test_random_traffic();

        // drain_replies has run; anything still queued never arrived
        if (expected_beats.size() != 0)
            note_failure($sformatf("%0d reply beats never arrived", expected_beats.size()));
        if (fail_count == 0)
            $display("tb_light_serial_command_responder_core: done, clean");
        else
            $display("tb_light_serial_command_responder_core: done, errors");
        $finish;
    end

endmodule
